// ----- rtl/igam_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// igam_pkg
// Shared types and constants of the IPv4 group rule matcher.
// ----------------------------------------------------------------------------
package igam_pkg;

  localparam logic [1:0] KIND_ADD   = 2'd0;
  localparam logic [1:0] KIND_CLEAR = 2'd1;
  localparam logic [1:0] KIND_QUERY = 2'd2;

  localparam logic [2:0] RT_SINGLE = 3'd0;
  localparam logic [2:0] RT_LOOP   = 3'd1;
  localparam logic [2:0] RT_RANGE  = 3'd2;
  localparam logic [2:0] RT_CIDR   = 3'd3;
  localparam logic [2:0] RT_REF    = 3'd4;

  localparam logic [31:0] LOOPBACK_ADDR = 32'h7F00_0001;

  // Stored rule word: type, group, addr a, addr b, target, reloadable.
  localparam int RULE_W = 3 + 4 + 32 + 32 + 4 + 1;

  typedef struct packed {
    logic [2:0]  rtype;
    logic [3:0]  group;
    logic [31:0] a;
    logic [31:0] b;
    logic [3:0]  target;
    logic        reload;
  } rule_t;

  function automatic logic [31:0] prefix_mask(input logic [5:0] p);
    logic [5:0] pc;
    pc = (p > 6'd32) ? 6'd32 : p;
    if (pc == 6'd0) return 32'd0;
    return 32'hFFFF_FFFF << (6'd32 - pc);
  endfunction

endpackage

// ----- rtl/igam_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// igam_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module igam_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

// ----- rtl/ip_group_acl_matcher.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ip_group_acl_matcher
// IPv4 rule table with groups, clears and reachability-based queries.
// ----------------------------------------------------------------------------
// Every item gives one result. An add runs a free-entry search that checks
// one entry per cycle on the valid bits; a partial clear sweeps the table
// once, while a full clear needs no sweep; a query of a nonzero address in an
// existing group takes one direct-match sweep plus up to MAX_GROUPS reference
// passes, each sweep going through the single RAM read port and one shared
// rule comparator (one read issued per entry, then the last registered read
// is compared, then the sweep closes). The block takes no transfer until its
// result is taken.
module ip_group_acl_matcher #(
  parameter int MAX_RULES  = 64,
  parameter int MAX_GROUPS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  // kind[1:0], group_id[5:2], rule_type[8:6], addr_a[40:9], addr_b[72:41],
  // prefix_len[78:73], target_group[82:79], reloadable[83], clear_all[84]
  input  logic [87:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // matched[0], group_found[1], status[2]
  output logic [7:0]  out_tdata
);
  import igam_pkg::*;

  localparam int AW = $clog2(MAX_RULES);
  localparam int CW = $clog2(MAX_RULES + 1);
  localparam int PW = $clog2(MAX_GROUPS + 1);
  // Group fields are 4 bits wide, so larger tables never see a higher index.
  localparam int GIW = ($clog2(MAX_GROUPS) < 4) ? $clog2(MAX_GROUPS) : 4;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_OUT  = 3'd2;

  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_CLR = 2'd1;
  localparam logic [1:0] OP_HIT = 2'd2;
  localparam logic [1:0] OP_REF = 2'd3;

  logic [2:0]  state_r, state_nxt;
  logic [1:0]  op_r, op_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [PW-1:0] pass_r, pass_nxt;
  logic        rd_vld_r, rd_vld_nxt;
  logic [AW-1:0] rd_idx_r, rd_idx_nxt;
  logic        changed_r, changed_nxt;
  logic [31:0] host_r;
  logic [MAX_RULES-1:0]  valid_r, valid_nxt;
  logic [MAX_GROUPS-1:0] gexist_r, gexist_nxt;
  logic [MAX_GROUPS-1:0] hit_r, hit_nxt, reach_r, reach_nxt;
  logic [31:0] ip_r;
  rule_t       new_r;
  logic [2:0]  res_r, res_nxt;

  logic        ram_we;
  logic [AW-1:0] ram_addr;
  rule_t       rdata;
  logic [RULE_W-1:0] rdata_raw;

  logic [1:0]  f_kind;
  logic [3:0]  f_gid, f_tgt;
  logic [2:0]  f_rt;
  logic [31:0] f_a, f_b, f_mask;
  logic [5:0]  f_plen;
  logic        f_rel, f_clr;

  assign f_kind = in_tdata[1:0];
  assign f_gid  = in_tdata[5:2];
  assign f_rt   = in_tdata[8:6];
  assign f_a    = in_tdata[40:9];
  assign f_b    = in_tdata[72:41];
  assign f_plen = in_tdata[78:73];
  assign f_tgt  = in_tdata[82:79];
  assign f_rel  = in_tdata[83];
  assign f_clr  = in_tdata[84];
  assign f_mask = prefix_mask(f_plen);

  assign rdata = rule_t'(rdata_raw);

  igam_ram #(.WIDTH(RULE_W), .DEPTH(MAX_RULES)) u_ram (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(new_r), .rdata(rdata_raw)
  );

  logic accept;
  assign accept    = in_tvalid && in_tready;
  assign in_tready = (state_r == S_IDLE);
  assign out_tvalid = (state_r == S_OUT);
  assign out_tdata  = {5'd0, res_r};

  // Shared rule comparator on the registered read.
  logic dmatch;
  always_comb begin
    case (rdata.rtype)
      RT_SINGLE: dmatch = (ip_r == rdata.a);
      RT_LOOP:   dmatch = (ip_r == LOOPBACK_ADDR) || (ip_r == host_r);
      RT_RANGE:  dmatch = (ip_r >= rdata.a) && (ip_r <= rdata.b);
      RT_CIDR:   dmatch = ((ip_r & rdata.b) == rdata.a);
      default:   dmatch = 1'b0;
    endcase
  end

  logic rd_live;
  assign rd_live = rd_vld_r && valid_r[rd_idx_r];
  logic last_addr;
  assign last_addr = (cnt_r == CW'(MAX_RULES - 1));

  always_comb begin
    state_nxt = state_r; op_nxt = op_r; cnt_nxt = cnt_r; pass_nxt = pass_r;
    rd_vld_nxt = 1'b0; rd_idx_nxt = cnt_r[AW-1:0]; changed_nxt = changed_r;
    valid_nxt = valid_r; gexist_nxt = gexist_r; hit_nxt = hit_r;
    reach_nxt = reach_r; res_nxt = res_r;
    ram_we = 1'b0; ram_addr = cnt_r[AW-1:0];
    case (state_r)
      S_IDLE: begin
        res_nxt = 3'd0; cnt_nxt = '0; pass_nxt = '0; changed_nxt = 1'b0;
        hit_nxt = '0; reach_nxt = '0;
        if (accept) begin
          state_nxt = S_OUT;
          case (f_kind)
            KIND_ADD: begin
              if (32'(f_gid) < MAX_GROUPS) begin
                gexist_nxt[f_gid[GIW-1:0]] = 1'b1;
                if (f_rt <= RT_REF) begin
                  state_nxt = S_SCAN; op_nxt = OP_ADD;
                end
              end
            end
            KIND_CLEAR: begin
              if (f_clr) begin
                valid_nxt = '0; gexist_nxt = '0;
              end else begin
                state_nxt = S_SCAN; op_nxt = OP_CLR;
              end
            end
            KIND_QUERY: begin
              if (32'(f_gid) < MAX_GROUPS && gexist_r[f_gid[GIW-1:0]]) begin
                res_nxt[1] = 1'b1;
                if (f_a != 32'd0) begin
                  state_nxt = S_SCAN; op_nxt = OP_HIT;
                  reach_nxt[f_gid[GIW-1:0]] = 1'b1;
                end
              end
            end
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        if (op_r == OP_ADD) begin
          // Free-entry search uses valid bits alone, one entry a cycle.
          if (!valid_r[cnt_r[AW-1:0]]) begin
            ram_we = 1'b1;
            valid_nxt[cnt_r[AW-1:0]] = 1'b1;
            state_nxt = S_OUT;
          end else if (last_addr) begin
            res_nxt[2] = 1'b1; state_nxt = S_OUT;
          end else cnt_nxt = cnt_r + 1'b1;
        end else begin
          if (cnt_r < CW'(MAX_RULES)) begin
            rd_vld_nxt = 1'b1; cnt_nxt = cnt_r + 1'b1;
          end
          if (rd_live) begin
            case (op_r)
              OP_CLR: if (rdata.reload) valid_nxt[rd_idx_r] = 1'b0;
              OP_HIT: if (32'(rdata.group) < MAX_GROUPS && dmatch)
                hit_nxt[rdata.group[GIW-1:0]] = 1'b1;
              default: begin
                if (rdata.rtype == RT_REF && 32'(rdata.group) < MAX_GROUPS &&
                    32'(rdata.target) < MAX_GROUPS &&
                    reach_r[rdata.group[GIW-1:0]] &&
                    gexist_r[rdata.target[GIW-1:0]] &&
                    !reach_r[rdata.target[GIW-1:0]]) begin
                  reach_nxt[rdata.target[GIW-1:0]] = 1'b1;
                  changed_nxt = 1'b1;
                end
              end
            endcase
          end
          if (cnt_r == CW'(MAX_RULES) && !rd_vld_r) begin
            // Sweep finished.
            cnt_nxt = '0; changed_nxt = 1'b0;
            case (op_r)
              OP_CLR: state_nxt = S_OUT;
              OP_HIT: op_nxt = OP_REF;
              default: begin
                pass_nxt = pass_r + 1'b1;
                if (!changed_r || pass_r == PW'(MAX_GROUPS - 1)) begin
                  state_nxt = S_OUT;
                  res_nxt[0] = |(reach_r & hit_r);
                end
              end
            endcase
          end
        end
      end
      S_OUT: if (out_tready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; valid_r <= '0; gexist_r <= '0; host_r <= 32'd0;
      rd_vld_r <= 1'b0;
    end else begin
      state_r <= state_nxt; valid_r <= valid_nxt; gexist_r <= gexist_nxt;
      rd_vld_r <= rd_vld_nxt;
      if (cfg_we) host_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    op_r <= op_nxt; cnt_r <= cnt_nxt; pass_r <= pass_nxt; rd_idx_r <= rd_idx_nxt;
    changed_r <= changed_nxt; hit_r <= hit_nxt; reach_r <= reach_nxt;
    res_r <= res_nxt;
    if (accept) begin
      ip_r <= f_a;
      new_r.rtype <= f_rt; new_r.group <= f_gid; new_r.target <= f_tgt;
      new_r.reload <= f_rel;
      new_r.a <= (f_rt == RT_CIDR) ? (f_a & f_mask) : f_a;
      new_r.b <= (f_rt == RT_CIDR) ? f_mask : f_b;
    end
  end

`ifndef SYNTHESIS
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !in_tready) else $error("ready while busy");
  a_match_found: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && res_r[0]) |-> res_r[1]) else $error("match without group");
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && res_r[2]) |-> (valid_r == '1)) else $error("full flag wrong");
  a_gid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && res_r[0]) |-> (ip_r != 32'd0))
    else $error("match on zero address");
`endif
endmodule

// ----- tb/ip_group_acl_matcher_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ip_group_acl_matcher_tb
// Drives adds, clears, queries and unused kinds into the IPv4 group rule matcher under
// random idling on both streams and checks every result against a
// scoreboard that keeps its own copy of the rule table and groups.
// ----------------------------------------------------------------------------
module ip_group_acl_matcher_tb;
  import igam_pkg::*;

  localparam int NRULES  = 64;
  localparam int NGROUPS = 16;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  typedef struct {
    logic [1:0]  kind;
    logic [3:0]  gid;
    logic [2:0]  rtype;
    logic [31:0] a;
    logic [31:0] b;
    logic [5:0]  plen;
    logic [3:0]  tgt;
    logic        reload;
    logic        clr_all;
  } acl_cmd_t;

  typedef struct {
    logic matched;
    logic found;
    logic status;
  } acl_resp_t;

  class acl_scoreboard;
    rule_t       rules[NRULES];
    bit          valid[NRULES];
    bit          exists[NGROUPS];
    logic [31:0] host_addr;
    acl_resp_t   pending[$];
    int          errors;
    int          checked;

    function void reset_state();
      foreach (valid[i]) valid[i] = 0;
      foreach (exists[i]) exists[i] = 0;
      host_addr = '0;
    endfunction

    function bit rule_hits(rule_t r, logic [31:0] ip);
      case (r.rtype)
        RT_SINGLE: return ip == r.a;
        RT_LOOP:   return ip == LOOPBACK_ADDR || ip == host_addr;
        RT_RANGE:  return ip >= r.a && ip <= r.b;
        RT_CIDR:   return (ip & r.b) == r.a;
        default:   return 0;
      endcase
    endfunction

    function void note_cmd(acl_cmd_t c);
      acl_resp_t   rs;
      int          slot;
      int          p;
      bit          hit[NGROUPS];
      bit          reach[NGROUPS];
      bit          changed;
      logic [5:0]  pc;
      logic [31:0] m;
      rs = '{0, 0, 0};
      case (c.kind)
        KIND_ADD: begin
          exists[c.gid] = 1;
          if (c.rtype <= RT_REF) begin
            slot = -1;
            for (int i = 0; i < NRULES; i++)
              if (!valid[i]) begin
                slot = i;
                break;
              end
            if (slot < 0) begin
              rs.status = 1;
            end else begin
              rules[slot] = '{c.rtype, c.gid, c.a, c.b, c.tgt, c.reload};
              if (c.rtype == RT_CIDR) begin
                pc = (c.plen > 6'd32) ? 6'd32 : c.plen;
                m = (pc == 0) ? 32'd0 : (32'hFFFF_FFFF << (32 - pc));
                rules[slot].a = c.a & m;
                rules[slot].b = m;
              end
              valid[slot] = 1;
            end
          end
        end
        KIND_CLEAR: begin
          if (c.clr_all) begin
            foreach (valid[i]) valid[i] = 0;
            foreach (exists[i]) exists[i] = 0;
          end else begin
            foreach (valid[i]) if (valid[i] && rules[i].reload) valid[i] = 0;
          end
        end
        KIND_QUERY: begin
          if (exists[c.gid]) begin
            rs.found = 1;
            if (c.a != 0) begin
              foreach (hit[g]) begin
                hit[g] = 0;
                reach[g] = 0;
              end
              for (int i = 0; i < NRULES; i++)
                if (valid[i] && rule_hits(rules[i], c.a)) hit[rules[i].group] = 1;
              reach[c.gid] = 1;
              for (p = 0; p < NGROUPS; p++) begin
                changed = 0;
                for (int i = 0; i < NRULES; i++) begin
                  if (valid[i] && rules[i].rtype == RT_REF && reach[rules[i].group] &&
                      exists[rules[i].target] && !reach[rules[i].target]) begin
                    reach[rules[i].target] = 1;
                    changed = 1;
                  end
                end
                if (!changed) break;
              end
              foreach (hit[g]) if (reach[g] && hit[g]) rs.matched = 1;
            end
          end
        end
        default: ;
      endcase
      pending.push_back(rs);
    endfunction

    function void check_resp(logic [7:0] d);
      acl_resp_t e;
      if (pending.size() == 0) begin
        $error("result 0x%0h with nothing expected", d);
        errors++;
        return;
      end
      e = pending.pop_front();
      checked++;
      if (d[0] !== e.matched) begin
        $error("matched: expected %0b actual %0b", e.matched, d[0]);
        errors++;
      end
      if (d[1] !== e.found) begin
        $error("group_found: expected %0b actual %0b", e.found, d[1]);
        errors++;
      end
      if (d[2] !== e.status) begin
        $error("status: expected %0b actual %0b", e.status, d[2]);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst_n = 0;
  logic        cfg_we = 0;
  logic [31:0] cfg_wdata = '0;
  logic        in_tvalid = 0;
  logic        in_tready;
  logic [87:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 0;
  logic [7:0]  out_tdata;

  acl_scoreboard acl_sb = new();
  bit          calm = 0;
  int          sent = 0;
  int          n_query = 0;
  int          n_match = 0;
  logic [31:0] addr_pool[8];

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  ip_group_acl_matcher dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  // Result side: random stall bursts until the quiet tail of the run.
  initial begin
    int n;
    forever begin
      @(negedge clk);
      if (!calm && $urandom_range(0, 3) == 0) begin
        out_tready <= 0;
        n = $urandom_range(1, 9);
        repeat (n) @(negedge clk);
      end
      out_tready <= 1;
    end
  end

  always @(posedge clk)
    if (rst_n && out_tvalid && out_tready) begin
      acl_sb.check_resp(out_tdata);
      if (out_tdata[0]) n_match++;
    end

  task automatic send_cmd(acl_cmd_t c);
    int n;
    // The previous transfer dropped valid at the current falling edge, so the
    // next item goes out on a later one.
    if (!calm && $urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 9);
      repeat (n) @(negedge clk);
    end else begin
      @(negedge clk);
    end
    in_tdata <= {3'b0, c.clr_all, c.reload, c.tgt, c.plen, c.b, c.a, c.rtype, c.gid,
                 c.kind};
    in_tvalid <= 1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    acl_sb.note_cmd(c);
    sent++;
    if (c.kind == KIND_QUERY) n_query++;
    @(negedge clk);
    in_tvalid <= 0;
  endtask

  task automatic drain();
    while (acl_sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_host(logic [31:0] v);
    @(negedge clk);
    cfg_we <= 1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 0;
    acl_sb.host_addr = v;
  endtask

  function automatic acl_cmd_t mk(logic [1:0] k, logic [3:0] g, logic [2:0] t,
                                  logic [31:0] a, logic [31:0] b, logic [5:0] p,
                                  logic [3:0] tg, logic rl, logic ca);
    acl_cmd_t c;
    c = '{k, g, t, a, b, p, tg, rl, ca};
    return c;
  endfunction

  function automatic logic [31:0] pick_addr();
    case ($urandom_range(0, 4))
      0: return $urandom();
      1: return LOOPBACK_ADDR;
      2: return acl_sb.host_addr;
      default: return addr_pool[$urandom_range(0, 7)] ^ $urandom_range(0, 3);
    endcase
  endfunction

  function automatic acl_cmd_t rand_cmd();
    acl_cmd_t    c;
    logic [31:0] x;
    int          r;
    c = mk(KIND_QUERY, 4'($urandom_range(0, 15)), 3'($urandom_range(0, 4)),
           pick_addr(), pick_addr(), 6'($urandom_range(0, 33)),
           4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)), 1'b0);
    r = $urandom_range(0, 99);
    if (r < 45) begin
      c.kind = KIND_ADD;
      if (c.rtype == RT_RANGE && c.a > c.b && $urandom_range(0, 3) != 0) begin
        x = c.a;
        c.a = c.b;
        c.b = x;
      end
      if ($urandom_range(0, 19) == 0) c.rtype = 3'($urandom_range(5, 7));
      if ($urandom_range(0, 9) == 0) c.plen = 6'($urandom_range(0, 63));
    end else if (r < 49) begin
      c.kind = KIND_CLEAR;
      c.clr_all = ($urandom_range(0, 3) == 0);
      c.a = $urandom();
    end else if (r < 51) begin
      c.kind = KIND_UNUSED;
      c.a = $urandom();
    end else if ($urandom_range(0, 19) == 0) begin
      c.a = 0;
    end
    return c;
  endfunction

  initial begin
    logic [31:0] host_vals[4];
    host_vals = '{32'hFFFF_FFFF, 32'h0A00_0005, 32'h0, 32'hC0A8_0101};
    acl_sb.reset_state();
    foreach (addr_pool[i]) addr_pool[i] = $urandom();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;
    write_host(32'hC0A8_0101);

    // Directed: every rule type, mask extremes, references with a cycle.
    send_cmd(mk(KIND_QUERY, 3, RT_SINGLE, 32'h0A000001, 0, 0, 0, 0, 0));
    send_cmd(mk(KIND_ADD, 0, RT_SINGLE, 32'hFFFFFFFF, 0, 0, 0, 1, 0));
    send_cmd(mk(KIND_ADD, 1, RT_LOOP, 0, 0, 0, 0, 0, 0));
    send_cmd(mk(KIND_ADD, 2, RT_RANGE, 32'h0A000000, 32'h0A0000FF, 0, 0, 1, 0));
    send_cmd(mk(KIND_ADD, 3, RT_CIDR, 32'hC0A8FFFF, 0, 16, 0, 0, 0));
    send_cmd(mk(KIND_ADD, 4, RT_CIDR, 32'h12345678, 0, 0, 0, 1, 0));
    send_cmd(mk(KIND_ADD, 5, RT_CIDR, 32'h12345678, 0, 63, 0, 0, 0));
    send_cmd(mk(KIND_ADD, 6, RT_REF, 0, 0, 0, 7, 0, 0));
    send_cmd(mk(KIND_ADD, 7, RT_REF, 0, 0, 0, 6, 1, 0));
    send_cmd(mk(KIND_ADD, 7, RT_REF, 0, 0, 0, 2, 0, 0));
    send_cmd(mk(KIND_ADD, 7, RT_REF, 0, 0, 0, 15, 0, 0));
    send_cmd(mk(KIND_ADD, 8, 3'd7, 32'hFFFFFFFF, 32'hFFFFFFFF, 6'h3F, 4'hF, 1, 1));
    send_cmd(mk(KIND_QUERY, 6, 0, 32'h0A000010, 0, 0, 0, 0, 0));
    send_cmd(mk(KIND_QUERY, 1, 0, LOOPBACK_ADDR, 0, 0, 0, 0, 0));
    send_cmd(mk(KIND_QUERY, 1, 0, 32'hC0A80101, 0, 0, 0, 0, 0));
    send_cmd(mk(KIND_QUERY, 3, 0, 32'hC0A81234, 0, 0, 0, 0, 0));
    send_cmd(mk(KIND_QUERY, 4, 0, 32'hFFFFFFFF, 0, 0, 0, 0, 0));
    send_cmd(mk(KIND_QUERY, 5, 0, 32'h12345678, 0, 0, 0, 0, 0));
    send_cmd(mk(KIND_QUERY, 0, 0, 32'hFFFFFFFF, 0, 0, 0, 0, 0));
    send_cmd(mk(KIND_QUERY, 8, 0, 0, 0, 0, 0, 0, 0));
    send_cmd(mk(KIND_UNUSED, 4'hF, 3'h7, 32'hFFFFFFFF, 32'hFFFFFFFF, 6'h3F, 4'hF, 1, 1));
    send_cmd(mk(KIND_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0));
    send_cmd(mk(KIND_QUERY, 2, 0, 32'h0A000010, 0, 0, 0, 0, 0));
    // Fill the table past its capacity so the full flag shows up.
    for (int i = 0; i < NRULES + 2; i++)
      send_cmd(mk(KIND_ADD, 4'(i % 16), RT_SINGLE, addr_pool[i % 8], 0, 0, 0,
                  1'(i % 2), 0));
    send_cmd(mk(KIND_CLEAR, 0, 0, 0, 0, 0, 0, 0, 1));

    for (int ph = 0; ph < 4; ph++) begin
      drain();
      write_host(host_vals[ph]);
      if (ph == 3) calm = 1;
      repeat (120) send_cmd(rand_cmd());
    end
    drain();
    $display("Sent %0d items, %0d queries (%0d matched), %0d results checked.",
             sent, n_query, n_match, acl_sb.checked);
    $display("Covered all rule kinds, full table, clears, group cycles, host writes.");
    if (acl_sb.errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Regression FAIL");
    $finish;
  end
endmodule
